// ===== hdl/pfd_pkg.sv =====
`timescale 1ns / 1ps

package pfd_pkg;

    // Width of one symbol code.
    localparam int unsigned SYM_W = 5;

    // Register indexes of the configuration port.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLACK    = 3'd5;

    // Width of one key row register and the filler symbol after reset.
    localparam int unsigned KEY_ROW_W   = 25;
    localparam logic [SYM_W-1:0] SLACK_RESET = 5'd22;

    typedef logic [SYM_W-1:0] t_sym;

    // One unit of work for the decrypting side: up to two pairs and the end mark.
    typedef struct packed {
        logic p0_valid;
        t_sym p0_a;
        t_sym p0_b;
        logic p1_valid;
        t_sym p1_a;
        t_sym p1_b;
        logic eom;
    } t_job;

    // One result as it leaves the block.
    typedef struct packed {
        t_sym plain_symbol;
        logic symbol_valid;
        logic bad_symbol;
        logic last;
    } t_res;

endpackage

// ===== hdl/playfair_decrypt_stream_unit.sv =====
`timescale 1ns / 1ps
// Playfair decryption of a stream of 5-bit symbol codes against a key square.
// Input channel: a symbol with its end-of-message flag is transferred at a
// clock edge with push high and full low. Symbols are paired in order; equal
// neighbours and an odd last symbol are paired with the filler symbol.
// Result channel: while empty is low the oldest result sits on the o_ ports
// and is transferred at an edge with pop high. Each pair gives up to two
// symbols (filler symbols are dropped), or one bad-symbol result when a
// member is missing from the key; an end of message with no symbol gives a
// bare end marker. o_last marks the final result of a message.
// An input reaches the o_ ports through the job queue, the batch register of
// the decrypting side and the result queue. One input is taken per cycle while
// the two-entry job queue has room; the decrypting side writes one result per
// cycle into a four-entry result queue while that queue has room. A pair of
// distinct symbols gives two results over two inputs, so such a stream runs at
// one input per cycle; repeated symbols give two results each and fall behind.
// When the receiver stalls the result queue fills, then the job queue, and
// full rises. Reset clears both queues, the held symbol, the key (all zeros)
// and sets the filler symbol to 22. Configuration writes are registered.
module playfair_decrypt_stream_unit #(
    parameter int unsigned ROWS = 5,
    parameter int unsigned COLS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [pfd_pkg::SYM_W-1:0]       i_cipher_symbol,
    input  logic                            i_end_of_message,
    output logic                            empty,
    input  logic                            pop,
    output logic [pfd_pkg::SYM_W-1:0]       o_plain_symbol,
    output logic                            o_symbol_valid,
    output logic                            o_bad_symbol,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pfd_pkg::KEY_ROW_W-1:0]   i_cfg_data
);
    import pfd_pkg::*;

    logic [ROWS-1:0][COLS-1:0][SYM_W-1:0] r_key;
    t_sym  r_slack;
    t_job  w_job_in;
    t_job  w_job_out;
    logic  w_job_push;
    logic  w_job_pop;
    logic  w_job_empty;
    t_res  w_res_in;
    t_res  w_res_out;
    logic  w_res_push;
    logic  w_res_full;

    // Configuration registers; rows beyond the square are not kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_slack <= SLACK_RESET;
        end else if (i_cfg_we) begin
            for (int r = 0; r < ROWS; r++) begin
                if (i_cfg_idx == CFG_KEY_ROW0 + CFG_IDX_W'(r)) begin
                    for (int c = 0; c < COLS; c++) begin
                        r_key[r][c] <= i_cfg_data[c*SYM_W +: SYM_W];
                    end
                end
            end
            if (i_cfg_idx == CFG_SLACK) begin
                r_slack <= i_cfg_data[SYM_W-1:0];
            end
        end
    end

    // Front: pairing of input symbols.
    pfd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_job_full       (full),
        .i_cipher_symbol  (i_cipher_symbol),
        .i_end_of_message (i_end_of_message),
        .i_slack          (r_slack),
        .o_job            (w_job_in),
        .o_job_push       (w_job_push)
    );

    // Queue of pairing jobs between the two sides.
    pfd_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    // Back: decryption and serialisation of results.
    pfd_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_key),
        .i_slack     (r_slack),
        .i_job       (w_job_out),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .o_res       (w_res_in),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    // Result queue facing the receiver.
    pfd_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_plain_symbol = w_res_out.plain_symbol;
    assign o_symbol_valid = w_res_out.symbol_valid;
    assign o_bad_symbol   = w_res_out.bad_symbol;
    assign o_last         = w_res_out.last;

`ifndef NO_ASSERTIONS
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_symbol_valid && !o_bad_symbol) |-> (o_last && o_plain_symbol == '0))
        else $error("bare result without end of message");
`endif

endmodule

// ===== hdl/pfd_fifo.sv =====
`timescale 1ns / 1ps

module pfd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [AW:0]      r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Storage for waiting entries.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == AW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue fill level beyond its depth");
`endif

endmodule

// ===== hdl/pfd_front.sv =====
`timescale 1ns / 1ps

module pfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_job_full,
    input  pfd_pkg::t_sym i_cipher_symbol,
    input  logic          i_end_of_message,
    input  pfd_pkg::t_sym i_slack,
    output pfd_pkg::t_job o_job,
    output logic          o_job_push
);
    import pfd_pkg::*;

    t_sym r_held;
    t_sym n_held;
    logic r_held_valid;
    logic n_held_valid;
    logic w_accept;
    t_job w_job;

    assign w_accept = i_push && !i_job_full;

    // Pairing of incoming symbols with the held one.
    always_comb begin
        n_held       = r_held;
        n_held_valid = r_held_valid;
        w_job        = '0;
        if (w_accept) begin
            if (r_held_valid) begin
                w_job.p0_valid = 1'b1;
                w_job.p0_a     = r_held;
                if (r_held == i_cipher_symbol) begin
                    // Equal neighbours: the first goes with the filler, the second stays.
                    w_job.p0_b = i_slack;
                    n_held     = i_cipher_symbol;
                end else begin
                    w_job.p0_b   = i_cipher_symbol;
                    n_held_valid = 1'b0;
                end
            end else begin
                n_held       = i_cipher_symbol;
                n_held_valid = 1'b1;
            end
            if (i_end_of_message) begin
                // A symbol left over at the end is paired with the filler.
                if (n_held_valid) begin
                    w_job.p1_valid = 1'b1;
                    w_job.p1_a     = n_held;
                    w_job.p1_b     = i_slack;
                end
                n_held_valid = 1'b0;
                n_held       = '0;
                w_job.eom    = 1'b1;
            end
        end
    end

    assign o_job      = w_job;
    assign o_job_push = w_accept && (w_job.p0_valid || w_job.p1_valid || w_job.eom);

    // Held symbol state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_valid <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_end_of_message) |=> (!r_held_valid && r_held == '0))
        else $error("symbol still held after the end of a message");
`endif

endmodule

// ===== hdl/pfd_back.sv =====
`timescale 1ns / 1ps

module pfd_back #(
    parameter int unsigned ROWS = 5,
    parameter int unsigned COLS = 5
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic [ROWS-1:0][COLS-1:0][pfd_pkg::SYM_W-1:0] i_key,
    input  pfd_pkg::t_sym                                i_slack,
    input  pfd_pkg::t_job                                i_job,
    input  logic                                         i_job_empty,
    output logic                                         o_job_pop,
    output pfd_pkg::t_res                                o_res,
    output logic                                         o_res_push,
    input  logic                                         i_res_full
);
    import pfd_pkg::*;

    localparam int unsigned RW = $clog2(ROWS);
    localparam int unsigned CW = $clog2(COLS);

    typedef logic [ROWS-1:0][COLS-1:0][SYM_W-1:0] t_key;

    typedef struct packed {
        logic          found;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
    } t_loc;

    // Result of one pair before the filler is dropped.
    typedef struct packed {
        logic       keep0;
        logic       keep1;
        logic       bad;
        t_sym       sym0;
        t_sym       sym1;
    } t_pair_out;

    // Position of a symbol; the last occurrence in row-major order wins.
    function automatic t_loc locate(input t_key key, input t_sym sym);
        t_loc loc;
        loc = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                if (key[r][c] == sym) begin
                    loc.found = 1'b1;
                    loc.row   = RW'(r);
                    loc.col   = CW'(c);
                end
            end
        end
        return loc;
    endfunction

    // Playfair rule for one pair.
    function automatic t_pair_out decrypt(input t_key key, input t_sym slack,
                                          input logic pv, input t_sym a, input t_sym b);
        t_pair_out po;
        t_loc      la;
        t_loc      lb;
        logic [RW-1:0] r0;
        logic [RW-1:0] r1;
        logic [CW-1:0] c0;
        logic [CW-1:0] c1;
        po = '0;
        la = locate(key, a);
        lb = locate(key, b);
        r0 = la.row;
        r1 = lb.row;
        c0 = la.col;
        c1 = lb.col;
        if (pv) begin
            if (!(la.found && lb.found)) begin
                po.bad   = 1'b1;
                po.keep0 = 1'b1;
            end else begin
                if (la.row == lb.row) begin
                    // Same row: one column to the left.
                    c0 = (la.col == '0) ? CW'(COLS-1) : la.col - 1'b1;
                    c1 = (lb.col == '0) ? CW'(COLS-1) : lb.col - 1'b1;
                end else if (la.col == lb.col) begin
                    // Same column: one row up.
                    r0 = (la.row == '0) ? RW'(ROWS-1) : la.row - 1'b1;
                    r1 = (lb.row == '0) ? RW'(ROWS-1) : lb.row - 1'b1;
                end else begin
                    // Rectangle: swap columns.
                    c0 = lb.col;
                    c1 = la.col;
                end
                po.sym0  = key[r0][c0];
                po.sym1  = key[r1][c1];
                po.keep0 = (po.sym0 != slack);
                po.keep1 = (po.sym1 != slack);
            end
        end
        return po;
    endfunction

    t_res      r_ent [4];
    t_res      n_ent [4];
    logic [3:0] r_mask;
    logic [3:0] n_mask;
    logic       r_eom;
    t_pair_out  w_p0;
    t_pair_out  w_p1;
    logic [1:0] w_idx;
    logic [3:0] w_rest;
    logic       w_emit;
    logic       w_done;
    logic       w_load;

    // Decrypt both pairs of the job at the queue head.
    always_comb begin
        w_p0 = decrypt(i_key, i_slack, i_job.p0_valid, i_job.p0_a, i_job.p0_b);
        w_p1 = decrypt(i_key, i_slack, i_job.p1_valid, i_job.p1_a, i_job.p1_b);
        n_ent[0] = '{plain_symbol: w_p0.bad ? '0 : w_p0.sym0, symbol_valid: !w_p0.bad,
                     bad_symbol: w_p0.bad, last: 1'b0};
        n_ent[1] = '{plain_symbol: w_p0.sym1, symbol_valid: 1'b1,
                     bad_symbol: 1'b0, last: 1'b0};
        n_ent[2] = '{plain_symbol: w_p1.bad ? '0 : w_p1.sym0, symbol_valid: !w_p1.bad,
                     bad_symbol: w_p1.bad, last: 1'b0};
        n_ent[3] = '{plain_symbol: w_p1.sym1, symbol_valid: 1'b1,
                     bad_symbol: 1'b0, last: 1'b0};
        n_mask   = {w_p1.keep1 && !w_p1.bad, w_p1.keep0,
                    w_p0.keep1 && !w_p0.bad, w_p0.keep0};
        // End of message with nothing to show: a bare end marker.
        if (i_job.eom && n_mask == '0) begin
            n_ent[0] = '0;
            n_mask   = 4'b0001;
        end
    end

    // Pick the oldest kept entry of the current batch.
    always_comb begin
        if (r_mask[0]) begin
            w_idx = 2'd0;
        end else if (r_mask[1]) begin
            w_idx = 2'd1;
        end else if (r_mask[2]) begin
            w_idx = 2'd2;
        end else begin
            w_idx = 2'd3;
        end
    end

    assign w_rest     = r_mask & ~(4'b0001 << w_idx);
    assign w_emit     = (r_mask != '0) && !i_res_full;
    assign w_done     = (r_mask == '0) || (w_emit && w_rest == '0);
    assign w_load     = w_done && !i_job_empty;
    assign o_job_pop  = w_load;
    assign o_res_push = w_emit;

    // Result transfer into the output queue.
    always_comb begin
        o_res      = r_ent[w_idx];
        o_res.last = r_eom && (w_rest == '0);
    end

    // Batch payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ent <= n_ent;
            r_eom <= i_job.eom;
        end
    end

    // Batch occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (w_load) begin
            r_mask <= n_mask;
        end else if (w_emit) begin
            r_mask <= w_rest;
        end
    end

`ifndef NO_ASSERTIONS
    a_eom_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && i_job.eom) |=> (r_mask != '0))
        else $error("end of message loaded with no result");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result written into a full queue");
    a_load_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_mask == '0 || (w_emit && $onehot(r_mask))))
        else $error("new batch loaded over waiting results");
`endif

endmodule
